/* src/ocls_pkg.sv */
// Shared types and constants for the ordered character list store.
// No dependencies; imported by the cell and the top level.
package ocls_pkg;

    localparam int DEPTH = 16;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_PUSH = 2'd0,
        CMD_FIND = 2'd1,
        CMD_REPL = 2'd2,
        CMD_DEL  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_MISS  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] key_char;
        logic [7:0] new_char;
    } t_cmd_word;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] match_pos;
        logic [4:0] entry_total;
    } t_res_word;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic       push;
        logic       repl;
        logic       del;
        logic [7:0] key_char;
        logic [7:0] new_char;
    } t_cell_ctl;

endpackage

/* src/ocls_cell.sv */
// One slot of the character chain: holds a character, compares it with the key
// and shifts towards its neighbours. Depends on ocls_pkg.
module ocls_cell
    import ocls_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_ctl  i_ctl,
    input  logic       i_occupied,
    input  logic       i_prior,
    input  logic [7:0] i_left_char,
    input  logic [7:0] i_right_char,
    output logic       o_prior,
    output logic       o_first,
    output logic [7:0] o_char
);

    logic [7:0] r_char;
    logic [7:0] n_char;
    logic       hit;

    assign hit     = i_occupied && (r_char == i_ctl.key_char);
    assign o_prior = i_prior | hit;
    assign o_first = hit & ~i_prior;
    assign o_char  = r_char;

    always_comb begin
        n_char = r_char;
        if (i_ctl.push) begin
            n_char = i_left_char;
        end else if (i_ctl.repl && o_first) begin
            n_char = i_ctl.new_char;
        end else if (i_ctl.del && o_prior) begin
            // close the gap from the first match onwards
            n_char = i_right_char;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char <= n_char;
    end

endmodule

/* src/ordered_char_list_store.sv */
// Top level of the ordered character list store: cell chain, count and result word.
// Depends on ocls_pkg and ocls_cell.
//
// One command is taken in every clock cycle (busy stays low) and its result word
// appears on o_res with o_valid in the next cycle; the receiver cannot
// stall it. The cycle is set by the key compare rippling along the chain of
// DEPTH cells to find the first match, followed by the shift into the slots.
// No clearing pass is needed after reset.
module ordered_char_list_store
    import ocls_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_cmd_word i_cmd,
    output logic      o_valid,
    output t_res_word o_res
);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_valid;
    t_res_word     r_res;
    t_res_word     n_res;

    t_cell_ctl     ctl;
    logic          accept;
    logic          full;
    logic          empty;
    logic          found;
    logic [PW-1:0] pos;

    logic [DEPTH:0]   prior;
    logic [DEPTH-1:0] first;
    logic [7:0]       chars [DEPTH];

    assign busy   = 1'b0;
    assign accept = start & ~busy;
    assign full   = (r_count == CW'(DEPTH));
    assign empty  = (r_count == '0);
    assign found  = prior[DEPTH];

    assign ctl.key_char = i_cmd.key_char;
    assign ctl.new_char = i_cmd.new_char;
    assign ctl.push     = accept && (i_cmd.cmd == CMD_PUSH) && !full;
    assign ctl.repl     = accept && (i_cmd.cmd == CMD_REPL) && found;
    assign ctl.del      = accept && (i_cmd.cmd == CMD_DEL) && found;

    assign prior[0] = 1'b0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [7:0] left_char;
        logic [7:0] right_char;

        assign left_char  = (g == 0) ? i_cmd.key_char : chars[(g == 0) ? 0 : g - 1];
        assign right_char = chars[(g == DEPTH - 1) ? g : g + 1];

        ocls_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (ctl),
            .i_occupied   (CW'(g) < r_count),
            .i_prior      (prior[g]),
            .i_left_char  (left_char),
            .i_right_char (right_char),
            .o_prior      (prior[g+1]),
            .o_first      (first[g]),
            .o_char       (chars[g])
        );
    end

    // at most one cell flags the first match
    always_comb begin
        pos = '0;
        for (int i = 0; i < DEPTH; i++) begin
            pos = pos | (first[i] ? PW'(i) : '0);
        end
    end

    always_comb begin
        n_count = r_count;
        if (ctl.push) begin
            n_count = r_count + CW'(1);
        end else if (ctl.del) begin
            n_count = r_count - CW'(1);
        end

        n_res.match_pos   = '0;
        n_res.entry_total = 5'(n_count);
        if (i_cmd.cmd == CMD_PUSH) begin
            n_res.status = full ? ST_FULL : ST_OK;
        end else if (empty) begin
            n_res.status = ST_EMPTY;
        end else if (!found) begin
            n_res.status = ST_MISS;
        end else begin
            n_res.status    = ST_OK;
            n_res.match_pos = 4'(pos);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept;
            if (accept) begin
                r_count <= n_count;
            end
        end
        if (accept) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_valid)
        else $error("command without result word");

    a_total_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_res.entry_total == 5'(r_count)))
        else $error("result total differs from held count");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && full && (i_cmd.cmd == CMD_PUSH)) |=>
            (o_res.status == ST_FULL) && (r_count == $past(r_count)))
        else $error("push on full list changed the count");
`endif

endmodule
